### rtl/rlcw_pkg.sv
// ----------------------------------------------------------------------------
// rlcw_pkg
// Shared types, constants and helper functions for the six-LED colour wave.
// ----------------------------------------------------------------------------
package rlcw_pkg;

  localparam int unsigned LedCount = 6;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned LevelW   = 8;

  localparam logic [LevelW-1:0] LevelMax = 8'd255;

  // Configuration register indexes
  localparam logic CFG_DIRECTION = 1'b0;
  localparam logic CFG_SPEED     = 1'b1;

  typedef enum logic [1:0] {
    PH_RED   = 2'd0,
    PH_BLUE  = 2'd1,
    PH_GREEN = 2'd2
  } phase_e;

  typedef struct packed {
    phase_e            phase;
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
  } led_t;

  localparam logic [LevelW-1:0] StartLevel [3] = '{8'd0, 8'd85, 8'd170};

  // Start pattern for one slot; direction 0 mirrors the pattern.
  function automatic led_t start_led(input logic dir, input logic [IdxW-1:0] slot);
    logic [IdxW-1:0] pos;
    led_t            led;
    pos       = dir ? slot : IdxW'(LedCount - 1) - slot;
    led.red   = '0;
    led.green = '0;
    led.blue  = '0;
    if (pos < IdxW'(3)) begin
      led.phase = PH_RED;
      led.red   = StartLevel[pos[1:0]];
    end else begin
      led.phase = PH_BLUE;
      led.blue  = StartLevel[2'(pos - IdxW'(3))];
    end
    return led;
  endfunction

  // Step period in ticks for a speed code.
  function automatic logic [2:0] step_period(input logic [2:0] code);
    logic [2:0] period;
    case (code)
      3'd1:    period = 3'd4;
      3'd2:    period = 3'd3;
      3'd3:    period = 3'd2;
      3'd4:    period = 3'd1;
      default: period = 3'd2;
    endcase
    return period;
  endfunction

endpackage

### rtl/rgb_led_color_wave_core.sv
// ----------------------------------------------------------------------------
// rgb_led_color_wave_core
// Six-LED multiplexed colour wave: one LED colour per tick beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one beat per tick or restart, tdata[0] = restart.
//   A restart beat reloads the start pattern (placed by the direction
//   register) and clears the scan and prescale counters; it gives no output.
//   A tick beat gives one output beat with the colour of the LED at the scan
//   position, then advances the scan and steps all six LEDs whenever the
//   prescaler reaches the period chosen by the speed register.
//   Output stream (m_axis_*): led index and red, green, blue levels.
//   The output beat is registered and appears in the cycle after its input
//   beat. Throughput: one beat per cycle while the output is taken; the whole
//   update of all six LEDs is done in the accepting cycle, and the output
//   register lets a new beat in while the last result is being taken.
//   Stall: while the output register holds an untaken beat and m_axis_tready
//   is low, s_axis_tready is low and all state holds.
//   Reset: pattern for direction 1, counters cleared, direction 1, speed 3.
//   Configuration writes (cfg_*) take effect at the clock edge; direction is
//   used at the next restart, speed at the next tick.
// ----------------------------------------------------------------------------
module rgb_led_color_wave_core import rlcw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [2:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [2:0] led_index, [10:3] red_level,
                                      // [18:11] green_level, [26:19] blue_level
);

  logic       dir_q;
  logic [2:0] speed_q;

  led_t            leds_q [LedCount];
  led_t            leds_d [LedCount];
  led_t            stepped [LedCount];
  logic [IdxW-1:0] scan_q, scan_d;
  logic [2:0]      presc_q, presc_d;

  logic        out_valid_q;
  logic [26:0] out_data_q, out_data_d;

  logic            in_fire, restart, tick;
  logic [IdxW-1:0] pos;
  logic [2:0]      presc_inc;
  logic            do_step;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign restart       = s_axis_tdata[0];
  assign tick          = in_fire && !restart;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_data_q};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= 1'b1;
      speed_q <= 3'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DIRECTION: dir_q   <= cfg_data_i[0];
        CFG_SPEED:     speed_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < LedCount; g++) begin : g_led
    rlcw_led_step u_step (
      .led_i (leds_q[g]),
      .led_o (stepped[g])
    );
  end

  always_comb begin
    pos        = (scan_q >= IdxW'(LedCount)) ? '0 : scan_q;
    out_data_d = {leds_q[pos].blue, leds_q[pos].green, leds_q[pos].red, pos};
    presc_inc  = presc_q + 3'd1;
    do_step    = presc_inc >= step_period(speed_q);
    scan_d     = scan_q;
    presc_d    = presc_q;
    leds_d     = leds_q;
    if (in_fire) begin
      if (restart) begin
        scan_d  = '0;
        presc_d = '0;
        for (int i = 0; i < LedCount; i++) begin
          leds_d[i] = start_led(dir_q, IdxW'(i));
        end
      end else begin
        scan_d  = (pos == IdxW'(LedCount - 1)) ? '0 : pos + IdxW'(1);
        presc_d = do_step ? '0 : presc_inc;
        if (do_step) begin
          leds_d = stepped;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= '0;
      presc_q <= '0;
      for (int i = 0; i < LedCount; i++) begin
        leds_q[i] <= start_led(1'b1, IdxW'(i));
      end
    end else begin
      scan_q  <= scan_d;
      presc_q <= presc_d;
      leds_q  <= leds_d;
    end
  end

  // output register: load on a tick, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      out_data_q <= out_data_d;
    end
  end

  // assertions
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q < IdxW'(LedCount))
    else $error("scan position out of range");

  a_presc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    presc_q < 3'd4)
    else $error("prescale count beyond longest period");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && restart) |=> (scan_q == '0 && presc_q == '0))
    else $error("restart did not clear counters");

  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick |=> (m_axis_tvalid && m_axis_tdata[2:0] == $past(pos)))
    else $error("tick did not give its result");

endmodule

### rtl/rlcw_led_step.sv
// ----------------------------------------------------------------------------
// rlcw_led_step
// One ramp step of a single LED towards its phase target, with phase advance.
// ----------------------------------------------------------------------------
module rlcw_led_step import rlcw_pkg::*; (
  input  led_t led_i,
  output led_t led_o
);

  function automatic logic [LevelW-1:0] ramp(input logic [LevelW-1:0] v,
                                             input logic [LevelW-1:0] tgt);
    logic [LevelW-1:0] r;
    if (v < tgt) begin
      r = v + LevelW'(1);
    end else if (v > tgt) begin
      r = v - LevelW'(1);
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [LevelW-1:0] tgt_r, tgt_g, tgt_b;
  phase_e            next_phase;
  logic              valid_phase;
  led_t              ramped;

  always_comb begin
    tgt_r       = '0;
    tgt_g       = '0;
    tgt_b       = '0;
    next_phase  = led_i.phase;
    valid_phase = 1'b1;
    unique case (led_i.phase)
      PH_RED: begin
        tgt_r      = LevelMax;
        next_phase = PH_BLUE;
      end
      PH_BLUE: begin
        tgt_b      = LevelMax;
        next_phase = PH_GREEN;
      end
      PH_GREEN: begin
        tgt_g      = LevelMax;
        next_phase = PH_RED;
      end
      default: valid_phase = 1'b0;
    endcase
  end

  always_comb begin
    ramped.phase = led_i.phase;
    ramped.red   = ramp(led_i.red,   tgt_r);
    ramped.green = ramp(led_i.green, tgt_g);
    ramped.blue  = ramp(led_i.blue,  tgt_b);
    // advance the phase on arrival at the target colour
    if (ramped.red == tgt_r && ramped.green == tgt_g && ramped.blue == tgt_b) begin
      ramped.phase = next_phase;
    end
    led_o = valid_phase ? ramped : led_i;
  end

endmodule

### bench/rlcw_checker.sv
// ----------------------------------------------------------------------------
// rlcw_checker
// Watches the tick stream, the colour stream and the register port of the
// colour wave core. Keeps its own copy of the six LEDs, predicts each colour
// beat from the accepted ticks and compares it field by field with the
// beats the core sends.
// ----------------------------------------------------------------------------
module rlcw_checker import rlcw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [2:0]  cfg_data_i,
  input  logic        tick_valid_i,
  input  logic        tick_ready_i,
  input  logic [7:0]  tick_data_i,    // [0] restart, [7:1] zero
  input  logic        colour_valid_i,
  input  logic        colour_ready_i,
  input  logic [31:0] colour_data_i,  // [2:0] led_index, [10:3] red_level,
                                      // [18:11] green_level, [26:19] blue_level
  output int          mismatch_count_o,
  output int          colours_checked_o,
  output int          colours_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IdxW-1:0]   idx;
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
  } colour_t;

  logic [LevelW-1:0] led_red   [LedCount];
  logic [LevelW-1:0] led_green [LedCount];
  logic [LevelW-1:0] led_blue  [LedCount];
  phase_e            led_phase [LedCount];
  logic [IdxW-1:0]   scan_pos;
  logic [2:0]        prescale;
  logic              direction;
  logic [2:0]        speed;
  colour_t           colour_q [$];
  int                mismatches = 0;
  int                checked = 0;

  function automatic logic [2:0] ticks_per_step(input logic [2:0] code);
    case (code)
      3'd1:    return 3'd4;
      3'd2:    return 3'd3;
      3'd3:    return 3'd2;
      3'd4:    return 3'd1;
      default: return 3'd2;
    endcase
  endfunction

  function automatic logic [LevelW-1:0] approach(input logic [LevelW-1:0] lvl,
                                                 input logic [LevelW-1:0] goal);
    if (lvl < goal) return lvl + 1'b1;
    if (lvl > goal) return lvl - 1'b1;
    return lvl;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // Direction 0 mirrors the pattern: LED k lands in slot 5-k.
  task automatic load_start_pattern(input logic dir);
    int k;
    int slot;
    for (k = 0; k < LedCount; k++) begin
      slot = dir ? k : LedCount - 1 - k;
      led_red[slot]   = '0;
      led_green[slot] = '0;
      led_blue[slot]  = '0;
      if (k < 3) begin
        led_phase[slot] = PH_RED;
        led_red[slot]   = LevelW'(85 * k);
      end else begin
        led_phase[slot] = PH_BLUE;
        led_blue[slot]  = LevelW'(85 * (k - 3));
      end
    end
  endtask

  task automatic step_all_leds();
    logic [LevelW-1:0] goal_r;
    logic [LevelW-1:0] goal_g;
    logic [LevelW-1:0] goal_b;
    phase_e            nxt;
    bit                known;
    int                i;
    for (i = 0; i < LedCount; i++) begin
      known  = 1'b1;
      goal_r = '0;
      goal_g = '0;
      goal_b = '0;
      nxt    = PH_RED;
      case (led_phase[i])
        PH_RED: begin
          goal_r = LevelMax;
          nxt    = PH_BLUE;
        end
        PH_BLUE: begin
          goal_b = LevelMax;
          nxt    = PH_GREEN;
        end
        PH_GREEN: begin
          goal_g = LevelMax;
          nxt    = PH_RED;
        end
        default: known = 1'b0;  // unused phase code: hold colour and phase
      endcase
      if (known) begin
        led_red[i]   = approach(led_red[i], goal_r);
        led_green[i] = approach(led_green[i], goal_g);
        led_blue[i]  = approach(led_blue[i], goal_b);
        if (led_red[i] == goal_r && led_green[i] == goal_g && led_blue[i] == goal_b)
          led_phase[i] = nxt;
      end
    end
  endtask

  // Colour is taken before this tick's prescaler step.
  task automatic predict_tick(output colour_t c);
    logic [IdxW-1:0] pos;
    pos     = (scan_pos >= LedCount) ? '0 : scan_pos;
    c.idx   = pos;
    c.red   = led_red[pos];
    c.green = led_green[pos];
    c.blue  = led_blue[pos];
    scan_pos = (pos == IdxW'(LedCount - 1)) ? '0 : pos + 1'b1;
    prescale = prescale + 1'b1;
    if (prescale >= ticks_per_step(speed)) begin
      prescale = '0;
      step_all_leds();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    colour_t want;
    colour_t got;
    if (!rst_ni) begin
      load_start_pattern(1'b1);
      scan_pos  = '0;
      prescale  = '0;
      direction = 1'b1;
      speed     = 3'd3;
      colour_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DIRECTION: direction = cfg_data_i[0];
          CFG_SPEED:     speed     = cfg_data_i;
          default:       ;
        endcase
      end
      // drain before fill: a beat never leaves in the cycle it was accepted
      if (colour_valid_i && colour_ready_i) begin
        got.idx   = colour_data_i[2:0];
        got.red   = colour_data_i[10:3];
        got.green = colour_data_i[18:11];
        got.blue  = colour_data_i[26:19];
        check_field("tdata padding", colour_data_i[31:27], 0);
        if (colour_q.size() == 0) begin
          report_mismatch($sformatf("colour beat with nothing pending (led %0d)", got.idx));
        end else begin
          want = colour_q.pop_front();
          checked++;
          check_field("led_index", got.idx, want.idx);
          check_field("red_level", got.red, want.red);
          check_field("green_level", got.green, want.green);
          check_field("blue_level", got.blue, want.blue);
        end
      end
      if (tick_valid_i && tick_ready_i) begin
        if (tick_data_i[0]) begin
          load_start_pattern(direction);
          scan_pos = '0;
          prescale = '0;
        end else begin
          predict_tick(want);
          colour_q.push_back(want);
        end
      end
    end
    mismatch_count_o  <= mismatches;
    colours_checked_o <= checked;
    colours_pending_o <= colour_q.size();
  end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives tick and restart beats into the colour wave core under changing
// direction and speed settings and varying back-pressure on both streams.
// The checker beside the core predicts and compares every colour beat.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rlcw_pkg::*;

  localparam int RandomPhases = 8;
  localparam int PhaseBeats   = 154;
  localparam int CycleLimit   = 400000;

  localparam logic [2:0] PhaseSpeed [RandomPhases] =
    '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6};

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_index_i   = CFG_DIRECTION;
  logic [2:0]  cfg_data_i    = 3'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [0] restart, [7:1] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;            // [2:0] led_index, [10:3] red_level,
                                        // [18:11] green_level, [26:19] blue_level

  int mismatch_count;
  int colours_checked;
  int colours_pending;

  int gap_pct   = 0;
  int stall_pct = 0;
  int ticks_sent    = 0;
  int restarts_sent = 0;
  int settings_made = 0;
  int cycle_count   = 0;

  rgb_led_color_wave_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rlcw_checker colour_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .tick_valid_i      (s_axis_tvalid),
    .tick_ready_i      (s_axis_tready),
    .tick_data_i       (s_axis_tdata),
    .colour_valid_i    (m_axis_tvalid),
    .colour_ready_i    (m_axis_tready),
    .colour_data_i     (m_axis_tdata),
    .mismatch_count_o  (mismatch_count),
    .colours_checked_o (colours_checked),
    .colours_pending_o (colours_pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d colour beats outstanding",
               cycle_count, colours_pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin gap_pct = 80; stall_pct = 0;  end
      IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 80; end
      default:       begin gap_pct = 13; stall_pct = 13; end
    endcase
  endtask

  // tvalid stays high between back-to-back beats; it drops only for a gap
  task automatic send_beat(input logic restart);
    if ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, restart};
    do @(posedge clk_i); while (!s_axis_tready);
    if (restart) restarts_sent++;
    else ticks_sent++;
  endtask

  // Write both registers once the core has drained; a restart leaves no
  // beat behind, so the wait runs on past the last colour beat.
  task automatic set_config(input logic dir, input logic [2:0] code);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (colours_pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_DIRECTION;
    cfg_data_i  <= {2'b00, dir};
    @(posedge clk_i);
    cfg_index_i <= CFG_SPEED;
    cfg_data_i  <= code;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_made++;
  endtask

  initial begin : stimulus
    int p;
    int n;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, double restart, late direction, speed cut
    set_idle(IDLE_NONE);
    repeat (8) send_beat(1'b0);
    repeat (2) send_beat(1'b1);
    repeat (3) send_beat(1'b0);
    set_config(1'b0, 3'd1);
    send_beat(1'b0);          // old pattern still running
    send_beat(1'b1);          // mirrored pattern from here
    repeat (3) send_beat(1'b0);
    set_config(1'b0, 3'd4);   // count of three already past a period of one
    repeat (2) send_beat(1'b0);
    set_config(1'b1, 3'd0);
    send_beat(1'b1);
    repeat (2) send_beat(1'b0);
    set_config(1'b1, 3'd7);
    repeat (2) send_beat(1'b0);

    // long tick runs so the LEDs pass through their phase changes
    for (p = 0; p < RandomPhases; p++) begin
      set_config(~p[0], PhaseSpeed[p]);
      set_idle(idle_mode_e'(p % 4));
      if ($urandom_range(1) == 1) send_beat(1'b1);
      for (n = 0; n < PhaseBeats; n++) send_beat($urandom_range(199) == 0);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (colours_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Sent %0d ticks and %0d restarts across %0d direction/speed settings",
             ticks_sent, restarts_sent, settings_made);
    $display("Checked %0d colour beats, %0d mismatches", colours_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
